// ===== src/nearest_palette_color_top_macros.svh =====
// ----------------------------------------------------------------------------
// nearest_palette_color_top_macros.svh
// Assertion macros shared by the nearest palette color modules.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define NPC_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define NPC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// Types and constants shared by the nearest palette color search block.
// ----------------------------------------------------------------------------
package npc_pkg;

   // Field widths
   localparam int COLOR_W = 6;
   localparam int INDEX_W = 8;
   localparam int ENTRY_W = 3 * COLOR_W;
   localparam int SQ_W    = 2 * COLOR_W;
   localparam int DIST_W  = 25;

   // Palette size default
   localparam int PALETTE_ENTRIES_DEF = 256;

   // Channel weights (squares of 30, 59 and 11)
   localparam int WEIGHT_RED   = 900;
   localparam int WEIGHT_GREEN = 3481;
   localparam int WEIGHT_BLUE  = 121;

   // Transparent pink query color
   localparam logic [COLOR_W-1:0] PINK_RED   = 6'd63;
   localparam logic [COLOR_W-1:0] PINK_GREEN = 6'd0;
   localparam logic [COLOR_W-1:0] PINK_BLUE  = 6'd63;

   // Action codes
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic write;    // store the request word in the palette
      logic load;     // capture a query and rewind the scan
      logic issue;    // read the next palette entry into the pipe
      logic finish;   // move the best index to the output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic issue_last;   // the scan address is the last entry
      logic pipe_busy;    // some entry is still in the distance pipe
   } sts_type;

endpackage

// ===== src/npc_ram.sv =====
// ----------------------------------------------------------------------------
// npc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module npc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/npc_dpath.sv =====
// ----------------------------------------------------------------------------
// npc_dpath
// Palette storage and the pipelined weighted-distance search.
// ----------------------------------------------------------------------------
module npc_dpath
   import npc_pkg::*;
#(
   parameter int ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [COLOR_W-1:0] req_red,
   input  logic [COLOR_W-1:0] req_green,
   input  logic [COLOR_W-1:0] req_blue,
   output sts_type            sts,
   output logic [INDEX_W-1:0] rsp_best_index
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Query and scan address
   logic [COLOR_W-1:0] q_red_ff, q_green_ff, q_blue_ff;
   logic [AW-1:0]      addr_ff;
   logic               is_pink;

   // Entry valid bits, cleared by reset
   logic [ENTRIES-1:0] ent_vld_ff, ent_vld_in;

   // RAM
   logic               wr_en;
   logic [ENTRY_W-1:0] rd_data;

   // Pipe stage 1: RAM read in flight
   logic               p1_vld_ff;
   logic [AW-1:0]      p1_idx_ff;
   logic               p1_ok_ff;
   // Stage 2: squared differences
   logic               p2_vld_ff;
   logic [AW-1:0]      p2_idx_ff;
   logic [SQ_W-1:0]    sq_r_ff, sq_g_ff, sq_b_ff;
   // Stage 3: weighted terms
   logic               p3_vld_ff;
   logic [AW-1:0]      p3_idx_ff;
   logic [DIST_W-1:0]  pr_r_ff, pr_g_ff, pr_b_ff;
   // Stage 4: distance
   logic               p4_vld_ff;
   logic [AW-1:0]      p4_idx_ff;
   logic [DIST_W-1:0]  dist_ff;

   // Running best
   logic               found_ff;
   logic [DIST_W-1:0]  lowest_ff;
   logic [AW-1:0]      best_ff;
   logic [INDEX_W-1:0] out_index_ff;

   // Entry fields after the valid mask
   logic [COLOR_W-1:0] e_red, e_green, e_blue;
   logic [COLOR_W-1:0] d_red, d_green, d_blue;

   assign is_pink = (req_red == PINK_RED) && (req_green == PINK_GREEN)
                    && (req_blue == PINK_BLUE);

   // Drop writes beyond the palette
   assign wr_en = cmd.write
                  && ({1'b0, req_entry_index} < (INDEX_W+1)'(ENTRIES));

   npc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_entry_index[AW-1:0]),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_en   (cmd.issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Mark written entries
   always_comb begin
      ent_vld_in = ent_vld_ff;
      if (wr_en) begin
         ent_vld_in[req_entry_index[AW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
      end else begin
         ent_vld_ff <= ent_vld_in;
      end
   end

   // Capture the query and rewind the scan; advance on each read
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_red_ff   <= req_red;
         q_green_ff <= req_green;
         q_blue_ff  <= req_blue;
         addr_ff    <= is_pink ? '0 : AW'(1);
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + AW'(1);
      end
   end

   // Unwritten entries read as zero
   assign e_red   = p1_ok_ff ? rd_data[ENTRY_W-1 -: COLOR_W] : '0;
   assign e_green = p1_ok_ff ? rd_data[2*COLOR_W-1 -: COLOR_W] : '0;
   assign e_blue  = p1_ok_ff ? rd_data[COLOR_W-1:0] : '0;

   assign d_red   = (e_red > q_red_ff) ? (e_red - q_red_ff) : (q_red_ff - e_red);
   assign d_green = (e_green > q_green_ff) ? (e_green - q_green_ff)
                                           : (q_green_ff - e_green);
   assign d_blue  = (e_blue > q_blue_ff) ? (e_blue - q_blue_ff) : (q_blue_ff - e_blue);

   // Pipe valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= cmd.issue;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
   end

   // Pipe payload: square, weight, sum
   always_ff @(posedge clock) begin
      p1_idx_ff <= addr_ff;
      p1_ok_ff  <= ent_vld_ff[addr_ff];
      p2_idx_ff <= p1_idx_ff;
      sq_r_ff   <= SQ_W'(d_red) * SQ_W'(d_red);
      sq_g_ff   <= SQ_W'(d_green) * SQ_W'(d_green);
      sq_b_ff   <= SQ_W'(d_blue) * SQ_W'(d_blue);
      p3_idx_ff <= p2_idx_ff;
      pr_r_ff   <= DIST_W'(sq_r_ff) * DIST_W'(WEIGHT_RED);
      pr_g_ff   <= DIST_W'(sq_g_ff) * DIST_W'(WEIGHT_GREEN);
      pr_b_ff   <= DIST_W'(sq_b_ff) * DIST_W'(WEIGHT_BLUE);
      p4_idx_ff <= p3_idx_ff;
      dist_ff   <= pr_r_ff + pr_g_ff + pr_b_ff;
   end

   // Keep the first strictly smallest distance
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (p4_vld_ff) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (p4_vld_ff && (!found_ff || (dist_ff < lowest_ff))) begin
         lowest_ff <= dist_ff;
         best_ff   <= p4_idx_ff;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_index_ff <= INDEX_W'(best_ff);
      end
   end

   assign rsp_best_index = out_index_ff;

   assign sts.issue_last = (addr_ff == AW'(ENTRIES - 1));
   assign sts.pipe_busy  = p1_vld_ff | p2_vld_ff | p3_vld_ff | p4_vld_ff;

`include "nearest_palette_color_top_macros.svh"

   `NPC_ASSERT_NEXT(a_found_after_entry, p4_vld_ff && !cmd.load, found_ff, "no best after entry")
   `NPC_ASSERT_NEXT(a_pipe_advance, p3_vld_ff, p4_vld_ff, "pipe lost an entry")
   `NPC_ASSERT_NOW(a_best_range, found_ff, {1'b0, best_ff} < (AW+1)'(ENTRIES), "best out of range")

endmodule

// ===== src/npc_ctrl.sv =====
// ----------------------------------------------------------------------------
// npc_ctrl
// Handshake and sequencing controller for the nearest palette color search.
// ----------------------------------------------------------------------------
module npc_ctrl
   import npc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_action,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_acc;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.write  = req_acc && (req_action == ACTION_WRITE);
      cmd.load   = req_acc && (req_action == ACTION_QUERY);
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy && (!rsp_valid_ff || !rsp_stall)) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result word until taken
   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`include "nearest_palette_color_top_macros.svh"

   `NPC_ASSERT_NEXT(a_query_scans, cmd.load, state_ff == ST_SCAN, "query did not start scan")
   `NPC_ASSERT_NEXT(a_finish_shows, cmd.finish, rsp_valid_ff && (state_ff == ST_IDLE), "result lost")
   `NPC_ASSERT_NOW(a_write_quiet, cmd.write, !sts.pipe_busy, "write during search")

endmodule

// ===== src/nearest_palette_color_top.sv =====
// A query scans PALETTE_ENTRIES palette entries, or one less unless the query is
// transparent pink, and reads one palette entry per cycle from the palette RAM
// read port. The input is held off during a query scan and drain; a finished
// result waits in the output register while the next word is taken.
// Reset clears the control state and marks every palette entry as zero.
// ----------------------------------------------------------------------------
// nearest_palette_color_top
// Nearest palette color search over a writable palette of 6-bit RGB entries.
// ----------------------------------------------------------------------------
module nearest_palette_color_top
   import npc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [COLOR_W-1:0] req_red,
   input  logic [COLOR_W-1:0] req_green,
   input  logic [COLOR_W-1:0] req_blue,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [INDEX_W-1:0] rsp_best_index
);

   cmd_type cmd;
   sts_type sts;

   npc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   npc_dpath #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .sts             (sts),
      .rsp_best_index  (rsp_best_index)
   );

endmodule
